/* rtl/affine_point_transform_assert.svh */
// assertion macros for the affine point transform block
// no dependencies; taken in by the top level
`ifndef AFFINE_POINT_TRANSFORM_ASSERT_SVH
`define AFFINE_POINT_TRANSFORM_ASSERT_SVH

`ifndef SYNTHESIS
`define APT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("apt: implication check failed");
`define APT_ASSERT_NEVER(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("apt: forbidden condition seen");
`else
`define APT_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define APT_ASSERT_NEVER(lbl, ck, rn, cond)
`endif

`endif

/* rtl/apt_pkg.sv */
// shared types, constants and helpers of the affine point transform
// no dependencies
package apt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 32;
  localparam int IDX_W       = 4;
  localparam int NUM_ROWS    = 3;
  localparam int NUM_COLS    = 3;
  localparam int ROW_STRIDE  = 4;
  localparam int NUM_COEF    = NUM_ROWS * ROW_STRIDE;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int IN_TDATA_W  = ((IDX_W + 4 * COORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 3 * COORD_W;

  localparam logic signed [COORD_W-1:0] COEF_ONE   = COORD_W'(64'(1) << FRAC_BITS);
  localparam logic signed [SUM_W-1:0]   ROUND_OFS  = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [COORD_W-1:0] COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } apt_op_t;

  // for a load, x carries the coefficient value
  typedef struct packed {
    apt_op_t                    op;
    logic [IDX_W-1:0]           coef_index;
    logic                       last;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } apt_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } apt_q_status_t;

  function automatic logic signed [COORD_W-1:0] apt_reset_coef(input int idx);
    logic signed [COORD_W-1:0] v;
    v = (idx % (ROW_STRIDE + 1) == 0) ? COEF_ONE : '0;
    return v;
  endfunction

endpackage

/* rtl/apt_front.sv */
// input stage: accepts items, drops out-of-range loads, feeds the queue
// depends on apt_pkg
module apt_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [apt_pkg::IN_TDATA_W-1:0]       in_tdata,   // coef_index, coef_value, x, y, z
  input  logic                                 in_tuser,   // opcode
  input  logic                                 in_tlast,   // last_point
  input  apt_pkg::apt_q_status_t               q_status,
  output logic                                 q_push,
  output apt_pkg::apt_entry_t                  q_entry
);

  logic                 f_valid_r, f_valid_nxt;
  apt_pkg::apt_entry_t  f_entry_r, f_entry_nxt;
  logic                 take;
  logic                 keep;

  always_comb begin
    f_entry_nxt.op         = apt_pkg::apt_op_t'(in_tuser);
    f_entry_nxt.coef_index = in_tdata[apt_pkg::IDX_W-1:0];
    f_entry_nxt.last       = in_tlast;
    f_entry_nxt.x          = in_tdata[apt_pkg::IDX_W +: apt_pkg::COORD_W];
    if (f_entry_nxt.op == apt_pkg::OP_POINT) begin
      f_entry_nxt.x = in_tdata[apt_pkg::IDX_W + apt_pkg::COORD_W +: apt_pkg::COORD_W];
    end
    f_entry_nxt.y = in_tdata[apt_pkg::IDX_W + 2 * apt_pkg::COORD_W +: apt_pkg::COORD_W];
    f_entry_nxt.z = in_tdata[apt_pkg::IDX_W + 3 * apt_pkg::COORD_W +: apt_pkg::COORD_W];
  end

  assign in_tready = !f_valid_r || !q_status.full;
  assign take      = in_tvalid && in_tready;
  assign q_push    = f_valid_r && !q_status.full;
  assign q_entry   = f_entry_r;
  assign keep      = (f_entry_nxt.op == apt_pkg::OP_POINT) ||
                     (32'(f_entry_nxt.coef_index) < apt_pkg::NUM_COEF);

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (take) begin
      f_valid_nxt = keep;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_entry_r <= f_entry_nxt;
    end
  end

endmodule

/* rtl/apt_fifo.sv */
// short queue between the front and the back
// depends on apt_pkg
module apt_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  apt_pkg::apt_entry_t     push_entry,
  input  logic                    pop,
  output apt_pkg::apt_entry_t     pop_entry,
  output apt_pkg::apt_q_status_t  status
);

  apt_pkg::apt_entry_t        q_mem_r [apt_pkg::QUEUE_DEPTH];
  logic [apt_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [apt_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [apt_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == apt_pkg::QCNT_W'(apt_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_entry    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* rtl/apt_back.sv */
// matrix store and three-stage transform pipeline with output register
// depends on apt_pkg
module apt_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  apt_pkg::apt_entry_t                   q_entry,
  input  apt_pkg::apt_q_status_t                q_status,
  output logic                                  q_pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [apt_pkg::OUT_TDATA_W-1:0]       out_tdata,  // out_x, out_y, out_z
  output logic                                  out_tuser,  // saturated
  output logic                                  out_tlast   // last_out
);

  localparam int C = apt_pkg::COORD_W;
  localparam int F = apt_pkg::FRAC_BITS;

  logic signed [C-1:0]                 m_r      [apt_pkg::NUM_COEF];
  logic signed [apt_pkg::PROD_W-1:0]   prod_r   [apt_pkg::NUM_ROWS][apt_pkg::NUM_COLS];
  logic signed [C-1:0]                 trans_r  [apt_pkg::NUM_ROWS];
  logic signed [apt_pkg::SUM_W-1:0]    sum_r    [apt_pkg::NUM_ROWS];
  logic                                a_valid_r, a_last_r;
  logic                                b_valid_r, b_last_r;
  logic                                o_valid_r, o_last_r, o_sat_r;
  logic signed [C-1:0]                 o_coord_r [apt_pkg::NUM_ROWS];
  logic signed [C-1:0]                 coord_nxt [apt_pkg::NUM_ROWS];
  logic [apt_pkg::NUM_ROWS-1:0]        row_sat;
  logic                                adv;
  logic                                pop_point;
  logic                                pop_load;
  logic signed [C-1:0]                 pt       [apt_pkg::NUM_COLS];

  assign adv       = !o_valid_r || out_tready;
  assign q_pop     = !q_status.empty && adv;
  assign pop_point = q_pop && (q_entry.op == apt_pkg::OP_POINT);
  assign pop_load  = q_pop && (q_entry.op == apt_pkg::OP_LOAD);
  assign pt[0]     = q_entry.x;
  assign pt[1]     = q_entry.y;
  assign pt[2]     = q_entry.z;

  // matrix store, identity after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < apt_pkg::NUM_COEF; i++) begin
        m_r[i] <= apt_pkg::apt_reset_coef(i);
      end
    end else if (pop_load) begin
      m_r[q_entry.coef_index] <= q_entry.x;
    end
  end

  // stage a: products
  always_ff @(posedge clk) begin
    if (adv) begin
      a_last_r <= q_entry.last;
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
        trans_r[r] <= m_r[r * apt_pkg::ROW_STRIDE + apt_pkg::NUM_COLS];
        for (int c = 0; c < apt_pkg::NUM_COLS; c++) begin
          prod_r[r][c] <= m_r[r * apt_pkg::ROW_STRIDE + c] * pt[c];
        end
      end
    end
  end

  // stage b: row sums with translation and rounding offset
  always_ff @(posedge clk) begin
    if (adv) begin
      b_last_r <= a_last_r;
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
        sum_r[r] <= apt_pkg::SUM_W'(prod_r[r][0]) + apt_pkg::SUM_W'(prod_r[r][1]) +
                    apt_pkg::SUM_W'(prod_r[r][2]) +
                    (apt_pkg::SUM_W'(trans_r[r]) <<< F) + apt_pkg::ROUND_OFS;
      end
    end
  end

  // stage c: scale down and saturate
  always_comb begin
    for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
      row_sat[r]   = !((&sum_r[r][apt_pkg::SUM_W-1:F+C-1]) ||
                       !(|sum_r[r][apt_pkg::SUM_W-1:F+C-1]));
      coord_nxt[r] = sum_r[r][F +: C];
      if (row_sat[r]) begin
        coord_nxt[r] = sum_r[r][apt_pkg::SUM_W-1] ? apt_pkg::COORD_MIN : apt_pkg::COORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_last_r <= b_last_r;
      o_sat_r  <= |row_sat;
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
        o_coord_r[r] <= coord_nxt[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= pop_point;
      b_valid_r <= a_valid_r;
      o_valid_r <= b_valid_r;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {o_coord_r[2], o_coord_r[1], o_coord_r[0]};
  assign out_tuser  = o_sat_r;
  assign out_tlast  = o_last_r;

endmodule

/* rtl/affine_point_transform.sv */
// an accepted point passes the front register, the queue, then the stage a, stage b and output registers
// throughput: one item per cycle while out_tready does not stall; stage a has nine parallel 32x32 multipliers
// coefficient loads give no result; loads to index 12..15 are dropped
// reset: synchronous active-low; clears the queue and pipeline, matrix back to identity
// depends on apt_pkg, apt_front, apt_fifo, apt_back, affine_point_transform_assert.svh
`include "affine_point_transform_assert.svh"
module affine_point_transform (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [apt_pkg::IN_TDATA_W-1:0]    in_tdata,   // coef_index, coef_value, point_x, point_y, point_z
  input  logic                              in_tuser,   // opcode
  input  logic                              in_tlast,   // last_point
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [apt_pkg::OUT_TDATA_W-1:0]   out_tdata,  // out_x, out_y, out_z
  output logic                              out_tuser,  // saturated
  output logic                              out_tlast   // last_out
);

  apt_pkg::apt_q_status_t q_status;
  apt_pkg::apt_entry_t    push_entry;
  apt_pkg::apt_entry_t    pop_entry;
  logic                   q_push;
  logic                   q_pop;
  logic                   any_clip;

  apt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  apt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  apt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_entry    (pop_entry),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign any_clip =
    (out_tdata[31:0]  == apt_pkg::COORD_MAX) || (out_tdata[31:0]  == apt_pkg::COORD_MIN) ||
    (out_tdata[63:32] == apt_pkg::COORD_MAX) || (out_tdata[63:32] == apt_pkg::COORD_MIN) ||
    (out_tdata[95:64] == apt_pkg::COORD_MAX) || (out_tdata[95:64] == apt_pkg::COORD_MIN);

  `APT_ASSERT_NEVER(a_no_push_full, clk, rst_n, q_push && q_status.full)
  `APT_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, q_pop && q_status.empty)
  `APT_ASSERT_IMP(a_sat_clipped, clk, rst_n, out_tvalid && out_tuser, any_clip)

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// testbench for affine_point_transform: coefficient loads and point transforms
// with random idling on both streams, checked against an in-bench fixed point predictor
// depends on apt_pkg and the affine_point_transform rtl
module tb;
  import apt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 950;

  typedef struct {
    apt_op_t                   op;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] val;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
    bit                        hold;
  } cmd_t;

  typedef struct {
    logic [2:0][COORD_W-1:0] coord;
    logic                    last;
    logic                    sat;
  } xform_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    in_tuser = OP_LOAD;
  logic                    in_tlast = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tuser;
  logic                    out_tlast;

  cmd_t   pend_q[$];
  xform_t xform_q[$];
  logic signed [COORD_W-1:0] coef_mem[NUM_COEF];

  int  gen_cnt;
  int  err_cnt;
  int  acc_cnt;
  int  point_cnt;
  int  load_cnt;
  int  sat_cnt;
  int  idle_cnt;
  int  in_gap;
  int  out_gap;
  bit  in_taken;

  affine_point_transform DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_matrix();
    for (int i = 0; i < NUM_COEF; i++) begin
      coef_mem[i] = (i % (ROW_STRIDE + 1) == 0) ? COEF_ONE : '0;
    end
  endfunction

  // exact row sums, rounded half up to whole units, saturated to 32 bits
  function automatic xform_t transform_point(cmd_t c);
    xform_t r;
    logic signed [79:0] acc;
    logic signed [79:0] m;
    logic signed [79:0] p[3];
    p[0] = c.x;
    p[1] = c.y;
    p[2] = c.z;
    r.sat = 1'b0;
    r.last = c.last;
    for (int row = 0; row < NUM_ROWS; row++) begin
      acc = '0;
      for (int col = 0; col < NUM_COLS; col++) begin
        m = coef_mem[row * ROW_STRIDE + col];
        acc = acc + m * p[col];
      end
      m = coef_mem[row * ROW_STRIDE + NUM_COLS];
      acc = acc + (m <<< FRAC_BITS);
      acc = acc + (80'sd1 <<< (FRAC_BITS - 1));
      acc = acc >>> FRAC_BITS;
      if (acc > 80'sd2147483647) begin
        r.coord[row] = COORD_MAX;
        r.sat = 1'b1;
      end else if (acc < -80'sd2147483648) begin
        r.coord[row] = COORD_MIN;
        r.sat = 1'b1;
      end else begin
        r.coord[row] = acc[COORD_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if ((acc_cnt / 64) % 5 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] edge_value();
    case ($urandom_range(0, 4))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return edge_value();
      1, 2: return $urandom;
      3: return int'($urandom_range(0, 8)) - 4;
      default: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return edge_value();
      1: return $urandom;
      2, 3: return COEF_ONE;
      default: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  task automatic add_load(input int idx, input logic signed [COORD_W-1:0] val);
    cmd_t c;
    c.op = OP_LOAD;
    c.idx = IDX_W'(idx);
    c.val = val;
    c.x = $urandom;
    c.y = $urandom;
    c.z = $urandom;
    c.last = 1'($urandom_range(0, 1));
    c.hold = 1'b0;
    pend_q.push_back(c);
    if (idx < NUM_COEF) gen_cnt++;
  endtask

  task automatic add_point(input logic signed [COORD_W-1:0] x, y, z, input logic last);
    cmd_t c;
    c.op = OP_POINT;
    c.idx = IDX_W'($urandom_range(0, 15));
    c.val = $urandom;
    c.x = x;
    c.y = y;
    c.z = z;
    c.last = last;
    c.hold = 1'b0;
    pend_q.push_back(c);
    gen_cnt++;
  endtask

  task automatic add_hold();
    cmd_t c;
    c.op = OP_LOAD;
    c.idx = '0;
    c.val = '0;
    c.x = '0;
    c.y = '0;
    c.z = '0;
    c.last = 1'b0;
    c.hold = 1'b1;
    pend_q.push_back(c);
  endtask

  // driver
  always @(negedge clk) begin
    bit nv;
    nv = in_tvalid && !in_taken;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!nv) begin
        if (pend_q.size() > 0 && pend_q[0].hold) begin
          if (xform_q.size() == 0) pend_q.pop_front();
        end else if (in_gap > 0) begin
          in_gap--;
        end else if (pend_q.size() > 0) begin
          in_tdata <= {4'b0, pend_q[0].z, pend_q[0].y, pend_q[0].x, pend_q[0].val,
                       pend_q[0].idx};
          in_tuser <= pend_q[0].op;
          in_tlast <= pend_q[0].last;
          nv = 1'b1;
          in_gap = pick_gap();
        end
      end
      in_tvalid <= nv;
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    xform_t want;
    string  axis[3];
    axis = '{"x", "y", "z"};
    in_taken = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (xform_q.size() == 0) begin
          $display("%0t: result with nothing expected, got %h sat %b last %b", $time,
                   out_tdata, out_tuser, out_tlast);
          err_cnt++;
        end else begin
          want = xform_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (out_tdata[i*COORD_W +: COORD_W] !== want.coord[i]) begin
              $display("%0t: out_%s expected %h got %h", $time, axis[i], want.coord[i],
                       out_tdata[i*COORD_W +: COORD_W]);
              err_cnt++;
            end
          end
          if (out_tuser !== want.sat) begin
            $display("%0t: saturated expected %b got %b", $time, want.sat, out_tuser);
            err_cnt++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, out_tlast);
            err_cnt++;
          end
          if (want.sat) sat_cnt++;
        end
      end
      if (in_taken) begin
        if (pend_q[0].op == OP_POINT) begin
          xform_q.push_back(transform_point(pend_q[0]));
          point_cnt++;
        end else begin
          if (pend_q[0].idx < NUM_COEF) coef_mem[pend_q[0].idx] = pend_q[0].val;
          load_cnt++;
        end
        pend_q.pop_front();
        acc_cnt++;
      end
      if (in_taken || (out_tvalid && out_tready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("affine_point_transform test failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    reset_matrix();

    // identity after reset, extremes pass through
    add_point(0, 0, 0, 1'b0);
    add_point(COORD_MAX, COORD_MIN, -1, 1'b1);
    // loads past the matrix are dropped
    add_load(12, 32'sd5);
    add_load(15, -1);
    add_point(32'sd3, 32'sd4, 32'sd5, 1'b0);
    // first point overflows and is clipped to the negative limit; the next two land near it unclipped
    add_load(0, COORD_MAX);
    add_load(1, COORD_MIN);
    add_load(3, COORD_MIN);
    add_point(COORD_MAX, COORD_MAX, 0, 1'b0);
    add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    add_point(0, 0, 0, 1'b0);
    // half-way cases round up
    add_load(0, 32'sh8000);
    add_load(1, 0);
    add_load(3, 0);
    add_point(32'sd1, 0, 0, 1'b0);
    add_point(-32'sd1, 0, 0, 1'b0);
    add_point(32'sd3, 0, 0, 1'b0);
    add_point(-32'sd3, 0, 0, 1'b1);
    add_load(0, COEF_ONE);
    add_load(7, 32'sh0002_8000);
    add_load(11, -32'sh0001_0000);
    add_point(32'sh0001_0000, -32'sh0002_0000, 32'sh7fff_0000, 1'b1);
    add_hold();

    gen_cnt = 0;
    while (gen_cnt < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 2) != 0) begin
          for (int i = 0; i < NUM_COEF; i++) begin
            if ($urandom_range(0, 3) != 0) add_load(i, rand_coef());
          end
        end
        n = $urandom_range(1, 24);
        for (int j = 0; j < n; j++) begin
          add_point(rand_coord(), rand_coord(), rand_coord(), j == n - 1);
        end
      end else begin
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 1) == 0) add_load($urandom_range(0, 15), rand_coef());
          else add_point($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        end
      end
      if ($urandom_range(0, 29) == 0) add_hold();
    end

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    while (pend_q.size() != 0 || xform_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (xform_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, xform_q.size());
      err_cnt++;
    end

    $display("covered %0d items: %0d coefficient loads and %0d point transforms,",
             acc_cnt, load_cnt, point_cnt);
    $display("%0d results clipped, with random stalls on both streams", sat_cnt);
    if (err_cnt == 0) begin
      $display("affine_point_transform test passed");
    end else begin
      $display("affine_point_transform test failed");
    end
    $finish;
  end

endmodule
